/* design/rwc_pkg.sv */
// Shared types, widths and constants of the RGB window convolution core.
package rwc_pkg;

  localparam int KERNEL_SIZE_DEF = 3;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT      = 4096;

  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int COEF_W    = 16;
  localparam int ROW_W     = 48;
  localparam int DIV_W     = 16;
  localparam int IW_W      = 11;
  localparam int IH_W      = 13;
  localparam int SUM_W     = 28;
  localparam int PROD_W    = 25;
  localparam int REM_W     = 30;
  localparam int DEN_W     = 17;
  localparam int Q_W       = 8;
  localparam int CFG_IDX_W = 3;
  localparam int STAGES    = 8;

  localparam logic [CH_W-1:0] CLAMP_MAX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAUSS    = 3'd0,
    REG_COEF_TOP = 3'd1,
    REG_COEF_MID = 3'd2,
    REG_COEF_BOT = 3'd3,
    REG_DIVISOR  = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } col_ctrl_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quot;
  } div_lane_t;

endpackage

/* design/rwc_col_cell.sv */
// One column cell of the 3x3 window: holds three pixels and passes them to its left neighbor.
module rwc_col_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rwc_pkg::col_ctrl_t ctrl_i,
  input  rwc_pkg::column_t   col_i,
  output rwc_pkg::column_t   col_o
);
  import rwc_pkg::*;

  column_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctrl_i.clear) begin
      col_q <= '0;
    end else if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

/* design/rwc_div_cell.sv */
// One restoring division cell: settles one quotient bit for a channel and registers the lane.
module rwc_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                           clk_i,
  input  logic [rwc_pkg::DEN_W-1:0]      den_i,
  input  rwc_pkg::div_lane_t             lane_i,
  output rwc_pkg::div_lane_t             lane_o
);
  import rwc_pkg::*;

  logic [REM_W-1:0] step;
  div_lane_t        lane_d;
  div_lane_t        lane_q;

  assign step = REM_W'(den_i) << SHIFT;

  always_comb begin
    lane_d = lane_i;
    if (lane_i.rem >= step) begin
      lane_d.rem         = lane_i.rem - step;
      lane_d.quot[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

/* design/rgb_window_convolution_core.sv */
// Top level of the RGB 3x3 window convolution core with line stores and divider chain.
// An item that yields a result passes from its acceptance through a line-store read, a
// multiply-accumulate over the nine taps (one tap each), divider setup and the eight-cell
// divider chain, and an output state that registers the result; the next item is accepted
// when the core is idle again; a stalled output holds the core until the result can load.
// Items without a result go back to idle after the read; in-frame drain beats are ignored.
// Reset (asynchronous, active low) loads register defaults and clears window and positions.
module rgb_window_convolution_core #(
  parameter int KERNEL_SIZE = rwc_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = rwc_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [rwc_pkg::CH_W-1:0]          red_in_i,
  input  logic [rwc_pkg::CH_W-1:0]          green_in_i,
  input  logic [rwc_pkg::CH_W-1:0]          blue_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rwc_pkg::CH_W-1:0]          red_out_o,
  output logic [rwc_pkg::CH_W-1:0]          green_out_o,
  output logic [rwc_pkg::CH_W-1:0]          blue_out_o,
  output logic                              frame_end_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rwc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rwc_pkg::ROW_W-1:0]         cfg_data_i
);
  import rwc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int P_W = WW + IH_W;

  state_e state_q, state_d;

  // Configuration registers.
  logic             gauss_q;
  logic [ROW_W-1:0] coef_q [3];
  logic [DIV_W-1:0] divisor_q;
  logic [IW_W-1:0]  width_q;
  logic [IH_W-1:0]  height_q;
  logic             cfg_we;
  logic             cfg_geom;

  logic [WW-1:0]    w_eff;
  logic [IH_W-1:0]  h_eff;
  logic [P_W-1:0]   total;

  logic [CW-1:0]    col_q;
  logic [IH_W-1:0]  row_q;
  logic [P_W-1:0]   pcnt_q;

  logic             in_acc;
  logic             restart_now;
  logic [CW-1:0]    c_a;
  logic [IH_W-1:0]  y_a;
  logic [P_W-1:0]   p_a;
  logic             in_frame;
  logic             ignore;
  logic             start;

  logic [CW-1:0]    cur_c_q;
  logic [IH_W-1:0]  cur_y_q;
  logic [P_W-1:0]   cur_p_q;
  logic [PIX_W-1:0] pix_q;

  logic [PIX_W-1:0] mem1 [MAX_WIDTH];
  logic [PIX_W-1:0] mem2 [MAX_WIDTH];
  logic [PIX_W-1:0] rd1_q;
  logic [PIX_W-1:0] rd2_q;

  column_t          ncol;
  column_t          win    [3];
  column_t          win_in [3];
  col_ctrl_t        win_ctrl;

  logic             c1;
  logic [CW-1:0]    ox;
  logic [IH_W-1:0]  oy;
  logic [2:0]       col_ok_d, row_ok_d;
  logic [2:0]       col_ok_q, row_ok_q;
  logic             emit;
  logic             fe_d;
  logic             fe_q;
  logic             row_wrap;

  logic [1:0]       dy_q, dx_q;
  column_t          s_col;
  logic [PIX_W-1:0] sample;
  logic [COEF_W-1:0] coef_sel;
  logic [COEF_W-1:0] wt;
  logic             tap_en;
  logic signed [PROD_W-1:0] prod [3];
  logic signed [SUM_W-1:0]  sum_q [3];

  logic [3:0]       div_cnt_q;
  logic [DIV_W-1:0] dval;
  logic [DEN_W-1:0] den_q;
  logic [2:0]       pos_q, sat_q;
  div_lane_t        lane [3][STAGES+1];
  div_lane_t        stage0_q [3];

  logic             out_load;
  logic             out_valid_q;
  logic [CH_W-1:0]  res [3];
  logic [CH_W-1:0]  out_q [3];
  logic             frame_end_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cfg_geom    = cfg_we && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gauss_q   <= 1'b1;
      coef_q[0] <= 48'h0001_0002_0001;
      coef_q[1] <= 48'h0002_0004_0002;
      coef_q[2] <= 48'h0001_0002_0001;
      divisor_q <= 16'd16;
      width_q   <= 11'd640;
      height_q  <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_GAUSS:    gauss_q   <= cfg_data_i[0];
        REG_COEF_TOP: coef_q[0] <= cfg_data_i;
        REG_COEF_MID: coef_q[1] <= cfg_data_i;
        REG_COEF_BOT: coef_q[2] <= cfg_data_i;
        REG_DIVISOR:  divisor_q <= cfg_data_i[DIV_W-1:0];
        REG_WIDTH:    width_q   <= cfg_data_i[IW_W-1:0];
        REG_HEIGHT:   height_q  <= cfg_data_i[IH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = IH_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = IH_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign total = P_W'(w_eff) * P_W'(h_eff);

  // Acceptance of an input beat.
  assign in_acc      = (state_q == ST_IDLE) && in_valid_i;
  assign restart_now = {1'b0, col_q} >= w_eff;
  assign c_a         = restart_now ? '0 : col_q;
  assign y_a         = restart_now ? '0 : row_q;
  assign p_a         = restart_now ? '0 : pcnt_q;
  assign in_frame    = p_a < total;
  assign ignore      = operation_i && in_frame;
  assign start       = in_acc && !ignore;

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_c_q <= c_a;
      cur_y_q <= y_a;
      cur_p_q <= p_a;
      pix_q   <= in_frame ? {red_in_i, green_in_i, blue_in_i} : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      rd1_q <= mem1[c_a];
      rd2_q <= mem2[c_a];
    end
    if (state_q == ST_READ) begin
      mem1[cur_c_q] <= pix_q;
      mem2[cur_c_q] <= rd1_q;
    end
  end

  // Window column and neighborhood of the output pixel.
  always_comb begin
    ncol.top = (cur_y_q >= IH_W'(2)) ? rd2_q : '0;
    ncol.mid = (cur_y_q >= IH_W'(1)) ? rd1_q : '0;
    ncol.bot = pix_q;
    c1       = cur_c_q != '0;
    ox       = c1 ? cur_c_q - CW'(1) : CW'(w_eff - WW'(1));
    oy       = c1 ? cur_y_q - IH_W'(1) : cur_y_q - IH_W'(2);
    col_ok_d[0] = ox != '0;
    col_ok_d[1] = 1'b1;
    col_ok_d[2] = c1 && ((WW'(ox) + WW'(1)) < w_eff);
    row_ok_d[0] = oy != '0;
    row_ok_d[1] = oy < h_eff;
    row_ok_d[2] = ({1'b0, oy} + (IH_W+1)'(1)) < {1'b0, h_eff};
    emit     = (cur_p_q >= P_W'(w_eff) + P_W'(1)) &&
               (cur_p_q < total + P_W'(w_eff) + P_W'(1));
    fe_d     = cur_p_q == total + P_W'(w_eff);
    row_wrap = ({1'b0, cur_c_q} + WW'(1)) >= w_eff;
  end

  assign win_in[2] = ncol;
  assign win_in[1] = win[2];
  assign win_in[0] = win[1];

  for (genvar gi = 0; gi < 3; gi++) begin : g_win
    rwc_col_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (win_ctrl),
      .col_i  (win_in[gi]),
      .col_o  (win[gi])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pcnt_q <= '0;
    end else if (cfg_geom || (in_acc && restart_now)) begin
      col_q  <= '0;
      row_q  <= '0;
      pcnt_q <= '0;
    end else if (state_q == ST_READ) begin
      if (emit && fe_d) begin
        col_q  <= '0;
        row_q  <= '0;
        pcnt_q <= '0;
      end else begin
        col_q  <= row_wrap ? '0 : cur_c_q + CW'(1);
        row_q  <= row_wrap ? cur_y_q + IH_W'(1) : cur_y_q;
        pcnt_q <= cur_p_q + P_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      col_ok_q <= col_ok_d;
      row_ok_q <= row_ok_d;
      fe_q     <= fe_d;
    end
  end

  // Tap selection and weight.
  always_comb begin
    s_col = win[dx_q];
    case (dy_q)
      2'd0:    sample = s_col.top;
      2'd1:    sample = s_col.mid;
      default: sample = s_col.bot;
    endcase
    case (dx_q)
      2'd0:    coef_sel = coef_q[dy_q][15:0];
      2'd1:    coef_sel = coef_q[dy_q][31:16];
      default: coef_sel = coef_q[dy_q][47:32];
    endcase
    if (KERNEL_SIZE < 3) begin
      if (dy_q == 2'd1 && dx_q == 2'd1) begin
        wt = gauss_q ? COEF_W'(1) : coef_q[0][15:0];
      end else begin
        wt = '0;
      end
    end else if (gauss_q) begin
      wt = COEF_W'(1) << ({1'b0, dy_q == 2'd1} + {1'b0, dx_q == 2'd1});
    end else begin
      wt = coef_sel;
    end
    tap_en = row_ok_q[dy_q] && col_ok_q[dx_q];
  end

  for (genvar gc = 0; gc < 3; gc++) begin : g_mul
    assign prod[gc] = $signed(wt) * $signed({1'b0, sample[PIX_W-1-CH_W*gc -: CH_W]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dy_q      <= '0;
      dx_q      <= '0;
      div_cnt_q <= '0;
    end else begin
      if (state_q == ST_READ) begin
        dy_q <= '0;
        dx_q <= '0;
      end else if (state_q == ST_MAC) begin
        if (dx_q == 2'd2) begin
          dx_q <= '0;
          dy_q <= dy_q + 2'd1;
        end else begin
          dx_q <= dx_q + 2'd1;
        end
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 4'd1;
      end else begin
        div_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (state_q == ST_READ) begin
        sum_q[i] <= '0;
      end else if (state_q == ST_MAC && tap_en) begin
        sum_q[i] <= sum_q[i] + SUM_W'(prod[i]);
      end
    end
  end

  // Divider setup and cell chain.
  assign dval = gauss_q ? DIV_W'(1 << (2 * (KERNEL_SIZE - 1))) : divisor_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_cnt_q == 4'd0) begin
      den_q <= {dval, 1'b0};
      for (int i = 0; i < 3; i++) begin
        pos_q[i]         <= !sum_q[i][SUM_W-1] && (sum_q[i] != '0);
        stage0_q[i].rem  <= (REM_W'($unsigned(sum_q[i])) << 1) + REM_W'(dval);
        stage0_q[i].quot <= '0;
        sat_q[i]         <= ((REM_W'($unsigned(sum_q[i])) << 1) + REM_W'(dval)) >=
                            (REM_W'({dval, 1'b0}) << 8);
      end
    end
  end

  for (genvar gc = 0; gc < 3; gc++) begin : g_lane
    assign lane[gc][0] = stage0_q[gc];
    for (genvar gs = 0; gs < STAGES; gs++) begin : g_cell
      rwc_div_cell #(
        .SHIFT (STAGES - 1 - gs)
      ) u_div (
        .clk_i  (clk_i),
        .den_i  (den_q),
        .lane_i (lane[gc][gs]),
        .lane_o (lane[gc][gs+1])
      );
    end
    assign res[gc] = !pos_q[gc] ? '0 : (sat_q[gc] ? CLAMP_MAX : lane[gc][STAGES].quot);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q[0]    <= res[0];
      out_q[1]    <= res[1];
      out_q[2]    <= res[2];
      frame_end_q <= fe_q;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = emit ? ST_MAC : ST_IDLE;
      ST_MAC: begin
        if (dy_q == 2'd2 && dx_q == 2'd2) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == 4'(STAGES)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = state_q != ST_IDLE;
    out_load       = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
    win_ctrl.shift = state_q == ST_READ;
    win_ctrl.clear = cfg_geom || (in_acc && restart_now) || (out_load && fe_q);
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];
  assign frame_end_o = frame_end_q;

`ifndef NO_ASSERTIONS
  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_valid_q) |=> out_valid_q)
    else $error("result not registered when output was free");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q == ST_OUT) && state_q == ST_IDLE && frame_end_q) |->
      (col_q == '0 && row_q == '0 && pcnt_q == '0))
    else $error("positions not cleared after frame end");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q <= 4'(STAGES)))
    else $error("divider chain counter overran");
`endif

endmodule
